[rtl/u8u16_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-16 stream decoder.
// Used by every module under rtl; depends on nothing.
package u8u16_pkg;

    localparam int BYTE_W = 8;
    localparam int UNIT_W = 21;
    localparam int REPL_W = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_UTF16_OUT   = 1'b0,
        REG_REPLACEMENT = 1'b1
    } cfg_reg_t;

    localparam logic             UTF16_OUT_RST   = 1'b1;
    localparam logic [REPL_W-1:0] REPL_CHAR_RST  = 16'h003F;

    localparam logic [UNIT_W-1:0] SUPP_BASE   = 21'h010000;
    localparam logic [15:0]       HI_SURR     = 16'hD800;
    localparam logic [15:0]       LO_SURR     = 16'hDC00;
    localparam logic [4:0]        SURR_TOP5   = 5'h1B;
    localparam logic [9:0]        SURR_TOP10  = 10'h01B;

    typedef struct packed {
        logic              utf16_out;
        logic [REPL_W-1:0] replacement_char;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        cnt;
        logic [UNIT_W-1:0] unit0;
        logic [UNIT_W-1:0] unit1;
    } result_t;

endpackage

[rtl/u8u16_cfg.sv]
// Configuration registers of the UTF-8 to UTF-16 decoder.
// Depends on u8u16_pkg.
module u8u16_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [u8u16_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [u8u16_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output u8u16_pkg::cfg_t                       cfg
);
    import u8u16_pkg::*;

    logic              utf16_out_reg;
    logic [REPL_W-1:0] repl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utf16_out_reg <= UTF16_OUT_RST;
            repl_reg      <= REPL_CHAR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_UTF16_OUT:   utf16_out_reg <= cfg_wdata[0];
                REG_REPLACEMENT: repl_reg      <= cfg_wdata[REPL_W-1:0];
                default:         ;
            endcase
        end
    end

    assign cfg.utf16_out        = utf16_out_reg;
    assign cfg.replacement_char = repl_reg;

endmodule

[rtl/u8u16_decode.sv]
// Input register, sequence state and single-pass decode of one UTF-8 byte.
// Depends on u8u16_pkg.
module u8u16_decode (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [u8u16_pkg::BYTE_W-1:0]     in_byte,
    input  u8u16_pkg::cfg_t                  cfg,
    input  logic                             load_ok,
    output logic                             load,
    output u8u16_pkg::result_t               res
);
    import u8u16_pkg::*;

    logic              vld_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [1:0]        rem_reg, rem_next;
    logic [2:0]        len_reg, len_next;
    logic [UNIT_W-1:0] acc_reg, acc_next;
    logic              skip_reg, skip_next;
    logic              fire;

    always_comb
    begin
        logic              cont;
        logic [UNIT_W-1:0] acc_sh;
        logic [UNIT_W-1:0] v;
        logic [UNIT_W-1:0] d;
        logic              fresh;

        cont   = (byte_reg[7:6] == 2'b10);
        acc_sh = {acc_reg[UNIT_W-7:0], byte_reg[5:0]};
        v      = acc_sh;
        d      = '0;
        fresh  = 1'b0;

        rem_next  = rem_reg;
        len_next  = len_reg;
        acc_next  = acc_reg;
        skip_next = skip_reg;
        res.cnt   = 2'd0;
        res.unit0 = '0;
        res.unit1 = '0;

        if (byte_reg == '0)
        begin
            rem_next  = '0;
            len_next  = '0;
            acc_next  = '0;
            skip_next = 1'b0;
        end
        else if (!(skip_reg && cont))
        begin
            skip_next = 1'b0;
            if (rem_reg != 2'd0 && cont)
            begin
                rem_next = rem_reg - 2'd1;
                acc_next = acc_sh;
                if (rem_reg == 2'd1)
                begin
                    rem_next = '0;
                    len_next = '0;
                    acc_next = '0;
                    if (len_reg == 3'd3 && v[15:11] == SURR_TOP5)
                        v = UNIT_W'(cfg.replacement_char);
                    if (len_reg == 3'd4 && v[20:11] == SURR_TOP10)
                        v = UNIT_W'(cfg.replacement_char);
                    res.cnt   = 2'd1;
                    res.unit0 = v;
                    if (len_reg == 3'd4 && v >= SUPP_BASE && cfg.utf16_out)
                    begin
                        d         = v - SUPP_BASE;
                        res.cnt   = 2'd2;
                        res.unit0 = UNIT_W'(HI_SURR | 16'(d[UNIT_W-1:10]));
                        res.unit1 = UNIT_W'(LO_SURR | {6'd0, d[9:0]});
                    end
                end
            end
            else
            begin
                fresh = 1'b1;
            end
        end

        if (fresh)
        begin
            rem_next = '0;
            len_next = '0;
            acc_next = '0;
            if (byte_reg[7] == 1'b0)
            begin
                res.cnt   = 2'd1;
                res.unit0 = UNIT_W'(byte_reg);
            end
            else if (byte_reg[7:6] == 2'b10 || byte_reg[7:3] == 5'b11111)
            begin
                skip_next = 1'b1;
            end
            else if (byte_reg[7:5] == 3'b110)
            begin
                acc_next = UNIT_W'(byte_reg[4:0]);
                rem_next = 2'd1;
                len_next = 3'd2;
            end
            else if (byte_reg[7:4] == 4'b1110)
            begin
                acc_next = UNIT_W'(byte_reg[3:0]);
                rem_next = 2'd2;
                len_next = 3'd3;
            end
            else
            begin
                acc_next = UNIT_W'(byte_reg[2:0]);
                rem_next = 2'd3;
                len_next = 3'd4;
            end
        end
    end

    assign fire     = vld_reg && (load_ok || res.cnt == 2'd0);
    assign load     = fire && (res.cnt != 2'd0);
    assign in_ready = !vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            rem_reg  <= '0;
            len_reg  <= '0;
            acc_reg  <= '0;
            skip_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                vld_reg <= in_valid;
            if (fire)
            begin
                rem_reg  <= rem_next;
                len_reg  <= len_next;
                acc_reg  <= acc_next;
                skip_reg <= skip_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            byte_reg <= in_byte;
    end

endmodule

[rtl/u8u16_outbuf.sv]
// Result register holding up to two code units and draining them in order.
// Depends on u8u16_pkg.
module u8u16_outbuf (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  u8u16_pkg::result_t                 res,
    output logic                               load_ok,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [u8u16_pkg::UNIT_W-1:0]       out_unit,
    output logic                               out_last
);
    import u8u16_pkg::*;

    logic [1:0]        cnt_reg;
    logic [UNIT_W-1:0] u0_reg;
    logic [UNIT_W-1:0] u1_reg;
    logic              pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign load_ok   = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);
    assign out_unit  = u0_reg;
    assign out_last  = (cnt_reg == 2'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (load)
            cnt_reg <= res.cnt;
        else if (pop)
            cnt_reg <= cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            u0_reg <= res.unit0;
            u1_reg <= res.unit1;
        end
        else if (pop)
        begin
            u0_reg <= u1_reg;
        end
    end

endmodule

[rtl/utf8_to_utf16_stream_decoder.sv]
// UTF-8 to UTF-16 stream decoder, top level.
// Depends on u8u16_pkg, u8u16_cfg, u8u16_decode and u8u16_outbuf.
//
// Usage:
//   s_axis carries one UTF-8 byte per transfer; a zero byte ends the string
//   and drops any partial sequence. m_axis carries decoded code units; tlast
//   marks the final unit caused by one input byte (low on the high half of a
//   surrogate pair). Bytes that complete nothing produce no transfer.
//   cfg_we/cfg_addr/cfg_wdata write utf16_out (index 0) and the replacement
//   code unit (index 1); write only while the stream is idle.
// Timing:
//   One byte per cycle while m_axis keeps up. A byte goes to the input register,
//   is decoded from there into the result register and is offered on m_axis
//   from that register. A byte that yields a surrogate pair holds the result
//   register until both halves are taken; a following byte that yields a unit
//   waits in the input register while the high half is still held.
// Reset:
//   rst_n clears the sequence state and empties both registers; utf16_out
//   returns to 1 and the replacement unit to 0x003F.
// Stall:
//   With m_axis_tready low the result register holds; bytes that yield nothing
//   still pass, the first byte that yields a unit waits in the input register,
//   then s_axis_tready drops.
module utf8_to_utf16_stream_decoder (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [u8u16_pkg::BYTE_W-1:0]           s_axis_tdata,   // [7:0] byte_in
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [u8u16_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // [20:0] code_unit, zero pad
    output logic                                   m_axis_tlast,
    input  logic                                   cfg_we,
    input  logic [u8u16_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [u8u16_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import u8u16_pkg::*;

    cfg_t              cfg;
    result_t           res;
    logic              load;
    logic              load_ok;
    logic [UNIT_W-1:0] out_unit;

    u8u16_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    u8u16_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .cfg      (cfg),
        .load_ok  (load_ok),
        .load     (load),
        .res      (res)
    );

    u8u16_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .res       (res),
        .load_ok   (load_ok),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_unit  (out_unit),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TDATA_W'(out_unit);

endmodule

[verif/utf8_to_utf16_stream_decoder_tb.sv]
// Self-checking testbench for utf8_to_utf16_stream_decoder: a directed byte table, then random
// UTF-8 traffic under several register settings, checked against an in-bench decoder model.
// Depends on u8u16_pkg and the decoder RTL only.
module utf8_to_utf16_stream_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u8u16_pkg::*;

    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_LIMIT = 2000;
    localparam int PHASE_ITEMS = 210;
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              last;
    } expected_unit_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_val;
        logic              known;
        logic              has_unit;
        logic [UNIT_W-1:0] unit;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    wire in_xfer = rst_n && s_axis_tvalid && s_axis_tready;
    wire out_xfer = rst_n && m_axis_tvalid && m_axis_tready;

    // decoder model state and register copies
    logic              split_pairs = UTF16_OUT_RST;
    logic [REPL_W-1:0] repl_unit = REPL_CHAR_RST;
    logic [1:0]        cont_left = '0;
    logic [2:0]        seq_len = '0;
    logic [UNIT_W-1:0] payload = '0;
    logic              skip_cont = 1'b0;
    logic [UNIT_W-1:0] step_units [2];
    int                step_n;

    expected_unit_t pending_units [$];

    int mismatches = 0;
    int bytes_sent = 0;
    int bytes_skipped = 0;
    int units_checked = 0;
    int high_halves = 0;
    int settings_used = 1;
    int burst_left = 0;
    int hold_req = 0;
    bit pressing = 1'b0;

    dir_row_t directed_rows [24] = '{
        '{8'h41, 1'b1, 1'b1, 21'h000041},
        '{8'h7F, 1'b1, 1'b1, 21'h00007F},
        '{8'h80, 1'b1, 1'b0, 21'h000000},
        '{8'hBF, 1'b1, 1'b0, 21'h000000},
        '{8'h01, 1'b1, 1'b1, 21'h000001},
        '{8'hFF, 1'b1, 1'b0, 21'h000000},
        '{8'h00, 1'b1, 1'b0, 21'h000000},
        '{8'hC3, 1'b0, 1'b0, 21'h000000},
        '{8'hA9, 1'b0, 1'b0, 21'h000000},
        '{8'hED, 1'b0, 1'b0, 21'h000000},
        '{8'hA0, 1'b0, 1'b0, 21'h000000},
        '{8'h80, 1'b1, 1'b1, 21'h00003F},
        '{8'hF0, 1'b0, 1'b0, 21'h000000},
        '{8'h9F, 1'b0, 1'b0, 21'h000000},
        '{8'h98, 1'b0, 1'b0, 21'h000000},
        '{8'h80, 1'b0, 1'b0, 21'h000000},
        '{8'hF7, 1'b0, 1'b0, 21'h000000},
        '{8'hBF, 1'b0, 1'b0, 21'h000000},
        '{8'hBF, 1'b0, 1'b0, 21'h000000},
        '{8'hBF, 1'b0, 1'b0, 21'h000000},
        '{8'hE2, 1'b0, 1'b0, 21'h000000},
        '{8'h41, 1'b1, 1'b1, 21'h000041},
        '{8'hC2, 1'b0, 1'b0, 21'h000000},
        '{8'h00, 1'b1, 1'b0, 21'h000000}
    };

    utf8_to_utf16_stream_decoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic emit_unit(input logic [UNIT_W-1:0] v);
        if (step_n < 2)
        begin
            step_units[step_n] = v;
            step_n++;
        end
    endtask

    task automatic drop_seq();
        cont_left = '0;
        seq_len = '0;
        payload = '0;
    endtask

    task automatic close_seq();
        logic [UNIT_W-1:0] v;
        logic [UNIT_W-1:0] d;
        v = payload;
        if (seq_len == 3'd3 && (v & 21'h00F800) == 21'h00D800)
            v = {5'b0, repl_unit};
        if (seq_len == 3'd4 && (v & 21'h1FF800) == 21'h00D800)
            v = {5'b0, repl_unit};
        if (seq_len == 3'd4 && v >= SUPP_BASE && split_pairs)
        begin
            d = v - SUPP_BASE;
            emit_unit({5'b0, HI_SURR | {5'b0, d[20:10]}});
            emit_unit({5'b0, LO_SURR | {6'b0, d[9:0]}});
        end
        else
            emit_unit(v);
        drop_seq();
    endtask

    task automatic start_seq(input logic [BYTE_W-1:0] b);
        if (b < 8'h80)
            emit_unit({13'b0, b});
        else if (b < 8'hC0)
            skip_cont = 1'b1;
        else if (b < 8'hE0)
        begin
            payload = {16'b0, b[4:0]};
            cont_left = 2'd1;
            seq_len = 3'd2;
        end
        else if (b < 8'hF0)
        begin
            payload = {17'b0, b[3:0]};
            cont_left = 2'd2;
            seq_len = 3'd3;
        end
        else if (b < 8'hF8)
        begin
            payload = {18'b0, b[2:0]};
            cont_left = 2'd3;
            seq_len = 3'd4;
        end
        else
            skip_cont = 1'b1;
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b, output bit dropped);
        bit is_cont;
        is_cont = (b[7:6] == 2'b10);
        dropped = 1'b0;
        step_n = 0;
        if (b == 8'h00)
        begin
            drop_seq();
            skip_cont = 1'b0;
        end
        else if (skip_cont && is_cont)
            dropped = 1'b1;
        else
        begin
            skip_cont = 1'b0;
            if (cont_left != 2'd0 && is_cont)
            begin
                payload = {payload[UNIT_W-7:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                    close_seq();
            end
            else
            begin
                drop_seq();
                start_seq(b);
            end
        end
    endtask

    task automatic queue_unit(input logic [UNIT_W-1:0] u, input logic last_flag);
        expected_unit_t e;
        e.unit = u;
        e.last = last_flag;
        pending_units.insert(pending_units.size(), e);
    endtask

    task automatic push_predicted();
        for (int i = 0; i < step_n; i++)
            queue_unit(step_units[i], i == step_n - 1);
    endtask

    // offer one byte, wait for its transfer, advance the model
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        bit dropped;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0 || pressing) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        decode_byte(b, dropped);
        if (dropped)
            bytes_skipped++;
        else
            bytes_sent++;
    endtask

    task automatic send_predicted(input logic [BYTE_W-1:0] b);
        send_byte(b);
        push_predicted();
    endtask

    // hold the input until every expected unit is out, then let the pipe settle
    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_units.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic split, input logic [REPL_W-1:0] repl);
        cfg_we <= 1'b1;
        cfg_addr <= REG_UTF16_OUT;
        cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, split};
        @(posedge clk);
        cfg_addr <= REG_REPLACEMENT;
        cfg_wdata <= repl;
        @(posedge clk);
        cfg_we <= 1'b0;
        split_pairs = split;
        repl_unit = repl;
        settings_used++;
    endtask

    function automatic logic [BYTE_W-1:0] rand_cont();
        logic [5:0] low;
        low = 6'($urandom_range(0, 63));
        return {2'b10, low};
    endfunction

    function automatic logic [BYTE_W-1:0] rand_lead(input int len);
        logic [4:0] low;
        low = 5'($urandom_range(0, 31));
        case (len)
            2: return {3'b110, low};
            3: return {4'b1110, low[3:0]};
            default: return {5'b11110, low[2:0]};
        endcase
    endfunction

    task automatic random_phase(input int target, input bit squeeze);
        int start;
        int kind;
        int len;
        int n_cont;
        int press_end;
        bit squeezed;
        bit paused;
        logic [BYTE_W-1:0] r;
        logic [BYTE_W-1:0] seq [$];
        start = bytes_sent;
        squeezed = 1'b0;
        paused = 1'b0;
        press_end = 0;
        while (bytes_sent - start < target)
        begin
            if (squeeze && !squeezed && bytes_sent - start >= target / 3)
            begin
                hold_req <= hold_req + 1;
                pressing = 1'b1;
                press_end = bytes_sent + 60;
                squeezed = 1'b1;
            end
            if (pressing && bytes_sent >= press_end)
                pressing = 1'b0;
            if (squeeze && !paused && bytes_sent - start >= 2 * target / 3)
            begin
                drain_and_settle();
                paused = 1'b1;
            end
            seq.delete();
            kind = $urandom_range(0, 99);
            if (kind < 20)
            begin
                r = 8'($urandom_range(1, 127));
                seq.insert(seq.size(), r);
            end
            else if (kind < 38)
            begin
                seq.insert(seq.size(), rand_lead(2));
                seq.insert(seq.size(), rand_cont());
            end
            else if (kind < 58)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    r = {3'b101, 5'($urandom_range(0, 31))};
                    seq.insert(seq.size(), 8'hED);
                    seq.insert(seq.size(), r);
                end
                else
                begin
                    seq.insert(seq.size(), rand_lead(3));
                    seq.insert(seq.size(), rand_cont());
                end
                seq.insert(seq.size(), rand_cont());
            end
            else if (kind < 78)
            begin
                seq.insert(seq.size(), rand_lead(4));
                if ($urandom_range(0, 4) == 0)
                begin
                    r = {3'b101, 5'($urandom_range(0, 31))};
                    seq.insert(seq.size(), 8'h8D);
                    seq.insert(seq.size(), r);
                end
                else
                begin
                    seq.insert(seq.size(), rand_cont());
                    seq.insert(seq.size(), rand_cont());
                end
                seq.insert(seq.size(), rand_cont());
            end
            else if (kind < 88)
            begin
                len = $urandom_range(2, 4);
                n_cont = $urandom_range(0, len - 2);
                seq.insert(seq.size(), rand_lead(len));
                repeat (n_cont) seq.insert(seq.size(), rand_cont());
                case ($urandom_range(0, 3))
                    0: r = 8'h00;
                    1: r = 8'($urandom_range(1, 127));
                    2: r = rand_lead($urandom_range(2, 4));
                    default: r = 8'hF8 | 8'($urandom_range(0, 7));
                endcase
                seq.insert(seq.size(), r);
            end
            else if (kind < 94)
            begin
                if ($urandom_range(0, 1) == 0)
                    r = rand_cont();
                else
                    r = 8'hF8 | 8'($urandom_range(0, 7));
                seq.insert(seq.size(), r);
                repeat ($urandom_range(0, 3)) seq.insert(seq.size(), rand_cont());
            end
            else if (kind < 97)
                seq.insert(seq.size(), 8'h00);
            else
            begin
                r = 8'($urandom_range(0, 255));
                seq.insert(seq.size(), r);
            end
            foreach (seq[j])
                send_predicted(seq[j]);
        end
        pressing = 1'b0;
    endtask

    initial
    begin : stimulus
        logic [REPL_W-1:0] rnd_repl;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].byte_val);
            if (!directed_rows[i].known)
                push_predicted();
            else if (directed_rows[i].has_unit)
                queue_unit(directed_rows[i].unit, 1'b1);
        end
        drain_and_settle();
        for (int p = 0; p < 4; p++)
        begin
            rnd_repl = 16'($urandom_range(0, 65535));
            case (p)
                0: write_config(1'b0, 16'hFFFF);
                1: write_config(1'b1, 16'h0000);
                2: write_config(1'b0, rnd_repl);
                default: write_config(1'b1, 16'hFFFD);
            endcase
            random_phase(PHASE_ITEMS, p == 1);
            drain_and_settle();
        end
        $display("Sent %0d UTF-8 bytes (%0d more skipped) and checked %0d code units, %0d of them",
                 bytes_sent, bytes_skipped, units_checked, high_halves);
        $display("high surrogates, over %0d register settings in both output modes.",
                 settings_used);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        int hold_seen;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_output
        expected_unit_t want;
        if (out_xfer)
        begin
            if (pending_units.size() == 0)
            begin
                $error("code_unit: no transfer expected, got 0x%06h last_of_run %0b",
                       m_axis_tdata[UNIT_W-1:0], m_axis_tlast);
                mismatches++;
            end
            else
            begin
                want = pending_units.pop_front();
                if (m_axis_tdata[UNIT_W-1:0] !== want.unit)
                begin
                    $error("code_unit: expected 0x%06h, got 0x%06h",
                           want.unit, m_axis_tdata[UNIT_W-1:0]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last_of_run: expected %0b, got %0b", want.last, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tdata[OUT_TDATA_W-1:UNIT_W] !== '0)
                begin
                    $error("tdata pad: expected 0, got 0x%0h",
                           m_axis_tdata[OUT_TDATA_W-1:UNIT_W]);
                    mismatches++;
                end
            end
            units_checked++;
            if (!m_axis_tlast)
                high_halves++;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (in_xfer || out_xfer)
                quiet = 0;
            else
                quiet++;
        end
        $error("no transfer on either side for %0d cycles, %0d units outstanding",
               IDLE_LIMIT, pending_units.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
rtl/u8u16_pkg.sv
rtl/u8u16_cfg.sv
rtl/u8u16_decode.sv
rtl/u8u16_outbuf.sv
rtl/utf8_to_utf16_stream_decoder.sv
verif/utf8_to_utf16_stream_decoder_tb.sv
